/* hw/rtl/tpd_pkg.sv */
// Shared types and constants for the terminated packet deframer.
// No dependencies; every other source file but tpd_checker refers to this package by scoped names.
package tpd_pkg;

  localparam int PacketBytes = 11;
  localparam int WindowBytes = PacketBytes - 1;

  localparam logic [7:0] DefaultEndMarker = 8'd101;

  typedef logic [3:0] gap_t;
  localparam gap_t GapMax = 4'd15;
  localparam gap_t GapMin = 4'(WindowBytes);

  typedef logic [7:0] byte_t;

  // Byte held in the input register.
  typedef struct packed {
    logic  valid;
    byte_t data;
  } rx_item_t;

  // Handshake between the frame check and the result register.
  typedef struct packed {
    logic fire;
    logic hit;
  } flow_t;

  typedef struct packed {
    byte_t              target_count;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
  } result_t;

endpackage

/* hw/rtl/tpd_in_stage.sv */
// Input register of the deframer: takes one byte per transfer.
// Depends on tpd_pkg.
module tpd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              fire,
  output tpd_pkg::rx_item_t item
);

  logic load;

  // Refill in the same cycle the held byte moves on.
  assign in_stall = item.valid && !fire;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (load) begin
      item.valid <= 1'b1;
    end else if (fire) begin
      item.valid <= 1'b0;
    end
    if (load) begin
      item.data <= rx_byte;
    end
  end

endmodule

/* hw/rtl/tpd_frame_check.sv */
// Byte window, gap counter and packet check of the deframer.
// Depends on tpd_pkg.
module tpd_frame_check (
  input  logic              clk,
  input  logic              rst,
  input  tpd_pkg::rx_item_t item,
  input  logic [7:0]        end_marker,
  input  logic              out_busy,
  output tpd_pkg::flow_t    flow,
  output tpd_pkg::result_t  result
);

  tpd_pkg::byte_t window [tpd_pkg::WindowBytes];
  tpd_pkg::gap_t  gap;
  tpd_pkg::gap_t  gap_next;
  tpd_pkg::byte_t sum;
  logic           match;

  // Payload sum as a balanced tree over the nine payload bytes.
  assign sum = ((window[0] + window[1]) + (window[2] + window[3]))
             + ((window[4] + window[5]) + (window[6] + window[7]))
             + window[8];

  assign match = (item.data == end_marker) && (gap >= tpd_pkg::GapMin)
              && (sum == window[tpd_pkg::WindowBytes-1]);

  // A byte that yields no result never waits on the output side.
  assign flow.fire = item.valid && (!match || !out_busy);
  assign flow.hit  = match;

  assign result.target_count = window[0];
  assign result.pos_x        = $signed({window[1], window[2]});
  assign result.pos_y        = $signed({window[3], window[4]});
  assign result.speed_x      = $signed({window[5], window[6]});
  assign result.speed_y      = $signed({window[7], window[8]});

  always_comb begin
    if (match) begin
      gap_next = 4'd1;
    end else if (gap < tpd_pkg::GapMax) begin
      gap_next = gap + 4'd1;
    end else begin
      gap_next = gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
      for (int k = 0; k < tpd_pkg::WindowBytes; k++) begin
        window[k] <= '0;
      end
    end else if (flow.fire) begin
      gap <= gap_next;
      for (int k = 0; k < tpd_pkg::WindowBytes - 1; k++) begin
        window[k] <= window[k+1];
      end
      window[tpd_pkg::WindowBytes-1] <= item.data;
    end
  end

endmodule

/* hw/rtl/tpd_out_stage.sv */
// Result register of the deframer: holds one decoded packet until transfer.
// Depends on tpd_pkg.
module tpd_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  tpd_pkg::flow_t      flow,
  input  tpd_pkg::result_t    result,
  output logic                out_busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          target_count,
  output logic signed [15:0]  pos_x,
  output logic signed [15:0]  pos_y,
  output logic signed [15:0]  speed_x,
  output logic signed [15:0]  speed_y
);

  tpd_pkg::result_t held;
  logic             load;

  assign load     = flow.fire && flow.hit;
  assign out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign target_count = held.target_count;
  assign pos_x        = held.pos_x;
  assign pos_y        = held.pos_y;
  assign speed_x      = held.speed_x;
  assign speed_y      = held.speed_y;

endmodule

/* hw/rtl/terminated_packet_deframer_top.sv */
// A terminator byte is registered in the input stage, then its packet in the result register.
// Throughput: one byte per cycle; only a stalled result holds back a terminator that matches.
// Reset (rst, synchronous, active high) clears the byte window, the gap counter and
// both valid flags, and sets the end marker back to 'e'.
// Depends on tpd_pkg, tpd_in_stage, tpd_frame_check, tpd_out_stage.
module terminated_packet_deframer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         target_count,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] speed_x,
  output logic signed [15:0] speed_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         end_marker
);

  tpd_pkg::rx_item_t item;
  tpd_pkg::flow_t    flow;
  tpd_pkg::result_t  result;
  logic              out_busy;
  logic [7:0]        marker;

  // Take a new marker only with no byte held or arriving.
  assign cfg_ready = !item.valid && !in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= tpd_pkg::DefaultEndMarker;
    end else if (cfg_valid && cfg_ready) begin
      marker <= end_marker;
    end
  end

  tpd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .fire     (flow.fire),
    .item     (item)
  );

  tpd_frame_check u_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .end_marker (marker),
    .out_busy   (out_busy),
    .flow       (flow),
    .result     (result)
  );

  tpd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .flow         (flow),
    .result       (result),
    .out_busy     (out_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .target_count (target_count),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .speed_x      (speed_x),
    .speed_y      (speed_y)
  );

endmodule

/* hw/rtl/tpd_checker.sv */
// Port-level checks for the deframer top, attached by the bind below.
// Depends on terminated_packet_deframer_top.
module tpd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         target_count,
  input logic signed [15:0] pos_x,
  input logic signed [15:0] speed_y
);

  // Reset empties both registers.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("deframer not empty after reset");

  // A new result follows a byte transfer on the input.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a byte transfer two cycles earlier");

  // Hold a stalled result.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(target_count) && $stable(pos_x) && $stable(speed_y)))
    else $error("stalled result changed");

endmodule

bind terminated_packet_deframer_top tpd_checker u_tpd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .target_count (target_count),
  .pos_x        (pos_x),
  .speed_y      (speed_y)
);

/* verif/tb.sv */
// Self-checking testbench for terminated_packet_deframer_top.
// Predicts accepted packets from the byte stream and compares every output transfer.
// Depends on tpd_pkg and the deframer RTL.
module tb;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 4;
  localparam int HoldCycles  = 80;
  localparam int PhaseBytes  = 75;

  class packet_tracker;
    tpd_pkg::byte_t   window [tpd_pkg::WindowBytes];
    tpd_pkg::gap_t    gap;
    tpd_pkg::byte_t   marker;
    tpd_pkg::result_t expected_packets [$];
    int               errors;
    int               bytes_taken;
    int               packets_matched;

    function new();
      foreach (window[k]) window[k] = '0;
      gap = '0;
      marker = tpd_pkg::DefaultEndMarker;
      errors = 0;
      bytes_taken = 0;
      packets_matched = 0;
    endfunction

    function void set_marker(tpd_pkg::byte_t m);
      marker = m;
    endfunction

    function int pending();
      return expected_packets.size();
    endfunction

    function void take_byte(tpd_pkg::byte_t b);
      tpd_pkg::byte_t   sum;
      tpd_pkg::result_t pkt;
      int               k;
      sum = '0;
      for (k = 0; k < tpd_pkg::WindowBytes - 1; k++) sum += window[k];
      bytes_taken++;
      if (b == marker && gap >= tpd_pkg::GapMin && sum == window[tpd_pkg::WindowBytes-1]) begin
        pkt.target_count = window[0];
        pkt.pos_x   = {window[1], window[2]};
        pkt.pos_y   = {window[3], window[4]};
        pkt.speed_x = {window[5], window[6]};
        pkt.speed_y = {window[7], window[8]};
        expected_packets.push_back(pkt);
        gap = 4'd1;
      end else if (gap != tpd_pkg::GapMax) begin
        gap = gap + 4'd1;
      end
      // shift in every byte, terminator included
      for (k = 0; k < tpd_pkg::WindowBytes - 1; k++) window[k] = window[k+1];
      window[tpd_pkg::WindowBytes-1] = b;
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_packet(tpd_pkg::result_t got);
      tpd_pkg::result_t want;
      if (expected_packets.size() == 0) begin
        $display("%0t: packet with no expectation, expected none, actual %0d %0d %0d %0d %0d",
                 $time, got.target_count, got.pos_x, got.pos_y, got.speed_x, got.speed_y);
        errors++;
        return;
      end
      want = expected_packets.pop_front();
      packets_matched++;
      field_check("target_count", want.target_count, got.target_count);
      field_check("pos_x", want.pos_x, got.pos_x);
      field_check("pos_y", want.pos_y, got.pos_y);
      field_check("speed_x", want.speed_x, got.speed_x);
      field_check("speed_y", want.speed_y, got.speed_y);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         target_count;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] speed_x;
  logic signed [15:0] speed_y;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         end_marker = '0;

  packet_tracker tracker = new();

  tpd_pkg::byte_t cur_marker = tpd_pkg::DefaultEndMarker;
  bit    sender_steady = 1'b0;
  bit    receiver_steady = 1'b0;
  bit    hold_request = 1'b0;
  int    holds_done = 0;
  int    marker_writes = 0;
  int    stall_cycles = 0;
  int    cycle_count = 0;

  terminated_packet_deframer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .target_count (target_count),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .speed_x      (speed_x),
    .speed_y      (speed_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .end_marker   (end_marker)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("terminated_packet_deframer_top verification failed");
      $finish;
    end
  end

  // Sample transfers at the edge, before the block updates.
  always @(posedge clk) begin
    tpd_pkg::result_t seen;
    if (!rst) begin
      if (in_valid && in_stall) stall_cycles++;
      if (in_valid && !in_stall) tracker.take_byte(rx_byte);
      if (out_valid && !out_stall) begin
        seen.target_count = target_count;
        seen.pos_x   = pos_x;
        seen.pos_y   = pos_y;
        seen.speed_x = speed_x;
        seen.speed_y = speed_y;
        tracker.match_packet(seen);
      end
    end
  end

  // Result side: random stall before each transfer, or one long hold when asked.
  initial begin
    int k;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        k = 0;
        while (k < HoldCycles) begin
          @(posedge clk);
          k++;
        end
        hold_request = 1'b0;
        holds_done++;
      end else begin
        k = receiver_steady ? 0 : $urandom_range(0, 8);
        if (k > 0) begin
          out_stall <= 1'b1;
          repeat (k) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid && !hold_request);
      end
    end
  end

  task automatic push_byte(input tpd_pkg::byte_t b);
    int idle;
    idle = sender_steady ? 0 : $urandom_range(0, 8);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Append the checksum (seeded with a preceding byte for back-to-back frames) and terminator.
  task automatic send_frame(input tpd_pkg::byte_t payload[$], input tpd_pkg::byte_t seed,
                            input bit corrupt);
    tpd_pkg::byte_t check;
    check = seed;
    foreach (payload[i]) check += payload[i];
    if (corrupt) check += tpd_pkg::byte_t'($urandom_range(1, 255));
    foreach (payload[i]) push_byte(payload[i]);
    push_byte(check);
    push_byte(cur_marker);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_marker(input tpd_pkg::byte_t m);
    cfg_valid  <= 1'b1;
    end_marker <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_marker = m;
    tracker.set_marker(m);
    marker_writes++;
  endtask

  task automatic random_frame(input bit chained, input bit corrupt);
    tpd_pkg::byte_t payload[$];
    repeat (chained ? 8 : 9) payload.push_back(tpd_pkg::byte_t'($urandom_range(0, 255)));
    send_frame(payload, chained ? cur_marker : tpd_pkg::byte_t'(0), corrupt);
  endtask

  task automatic run_mixed(input int count);
    int sent;
    int good;
    int kind;
    int n;
    sent = 0;
    good = 0;
    while (sent < count || good < 6) begin
      sender_steady   = ($urandom_range(0, 5) == 0);
      receiver_steady = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        random_frame(1'b0, 1'b0);
        sent += 11;
        good++;
      end else if (kind == 7) begin
        random_frame(1'b0, 1'b1);
        sent += 11;
      end else if (kind == 8) begin
        random_frame(1'b1, 1'b0);
        sent += 10;
        good++;
      end else begin
        // noise with stray terminators
        n = $urandom_range(1, 15);
        repeat (n) push_byte(($urandom_range(0, 3) == 0) ? cur_marker
                                 : tpd_pkg::byte_t'($urandom_range(0, 255)));
        sent += n;
      end
    end
  endtask

  initial begin
    tpd_pkg::byte_t payload[$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // terminator right after reset: window sums match but the gap is too short
    push_byte(cur_marker);
    // all-ones payload
    payload = {};
    repeat (9) payload.push_back(8'hFF);
    send_frame(payload, 8'h00, 1'b0);
    // spacing of exactly ten: previous terminator becomes the count byte
    payload = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF};
    send_frame(payload, cur_marker, 1'b0);
    // checksum mismatch
    payload = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
    send_frame(payload, 8'h00, 1'b1);
    // gap counter saturates before this all-zero frame closes
    payload = {};
    repeat (9) payload.push_back(8'h00);
    send_frame(payload, 8'h00, 1'b0);

    settle();
    write_marker(8'h00);
    run_mixed(PhaseBytes);

    settle();
    write_marker(8'hFF);
    run_mixed(PhaseBytes);
    // hold the result side while frames keep arriving back to back
    hold_request = 1'b1;
    sender_steady = 1'b1;
    repeat (8) random_frame(1'b0, 1'b0);

    settle();
    write_marker(tpd_pkg::byte_t'($urandom_range(1, 254)));
    run_mixed(PhaseBytes);

    settle();
    write_marker(tpd_pkg::DefaultEndMarker);
    run_mixed(PhaseBytes);

    settle();
    $display("Run covered %0d bytes under %0d end-marker writes and checked %0d packets.",
             tracker.bytes_taken, marker_writes, tracker.packets_matched);
    $display("Result side held off %0d time(s); input stalled on %0d cycles.",
             holds_done, stall_cycles);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("terminated_packet_deframer_top verification clean");
    end else begin
      $display("terminated_packet_deframer_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_in_stage.sv
hw/rtl/tpd_frame_check.sv
hw/rtl/tpd_out_stage.sv
hw/rtl/terminated_packet_deframer_top.sv
hw/rtl/tpd_checker.sv
verif/tb.sv
